@@ rtl/qapm_pkg.sv @@
// ----------------------------------------------------------------------------
// qapm_pkg
// Shared types and constants for the quadcopter attitude PID and motor mixer.
// ----------------------------------------------------------------------------
package qapm_pkg;

  localparam int GAIN_FRAC_BITS = 10;
  localparam int SUM_SHIFT      = GAIN_FRAC_BITS + 16;
  localparam int SUM_W          = 56;
  localparam int ERR_SHIFT      = 8;
  localparam int GYRO_SHIFT     = 16;
  localparam int DIV12_SHIFT    = 16;

  localparam logic [12:0] STICK_CENTRE   = 13'd1500;
  localparam logic [11:0] YAW_DEAD_LO    = 12'd1400;
  localparam logic [11:0] YAW_DEAD_HI    = 12'd1600;
  localparam logic [11:0] THROTTLE_MIN   = 12'd1200;
  localparam logic [11:0] THROTTLE_BASE  = 12'd1000;
  localparam logic [12:0] DIV12_RECIP    = 13'd5462;

  localparam logic signed [21:0] INTEG_LIMIT = 22'sd512000;
  localparam logic signed [22:0] YAW_LIMIT   = 23'sd1310720;

  typedef enum logic [3:0] {
    CFG_ROLL_P  = 4'd0,
    CFG_ROLL_I  = 4'd1,
    CFG_ROLL_D  = 4'd2,
    CFG_PITCH_P = 4'd3,
    CFG_PITCH_I = 4'd4,
    CFG_PITCH_D = 4'd5,
    CFG_YAW_P   = 4'd6,
    CFG_YAW_D   = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] roll_p;
    logic [15:0] roll_i;
    logic [15:0] roll_d;
    logic [15:0] pitch_p;
    logic [15:0] pitch_i;
    logic [15:0] pitch_d;
    logic [15:0] yaw_p;
    logic [15:0] yaw_d;
  } gains_t;

  typedef struct packed {
    logic signed [16:0] roll_angle;
    logic signed [16:0] pitch_angle;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic [11:0]        stick_roll;
    logic [11:0]        stick_pitch;
    logic [11:0]        stick_yaw;
    logic [11:0]        throttle;
    logic               armed;
  } in_word_t;

  typedef struct packed {
    logic signed [17:0] er;
    logic signed [17:0] ep;
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic signed [15:0] gz;
    logic               run;
    logic               low;
    logic [11:0]        base;
  } err_word_t;

  typedef struct packed {
    logic signed [17:0] er;
    logic signed [17:0] ep;
    logic signed [20:0] ri;
    logic signed [20:0] pi;
    logic signed [21:0] ya;
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic signed [15:0] gz;
    logic               run;
    logic [11:0]        base;
  } integ_word_t;

  typedef struct packed {
    logic signed [34:0] pr;
    logic signed [37:0] ir;
    logic signed [32:0] dr;
    logic signed [34:0] pp;
    logic signed [37:0] ip;
    logic signed [32:0] dp;
    logic signed [38:0] yp;
    logic signed [32:0] yd;
    logic signed [15:0] gz;
    logic               run;
    logic [11:0]        base;
  } prod_word_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] r;
    logic signed [SUM_W-1:0] p;
    logic signed [SUM_W-1:0] y;
    logic signed [SUM_W-1:0] base;
    logic signed [15:0]      gz;
    logic                    run;
  } rpy_word_t;

  typedef struct packed {
    logic signed [15:0] motor_front_a;
    logic signed [15:0] motor_front_b;
    logic signed [15:0] motor_rear_a;
    logic signed [15:0] motor_rear_b;
    logic signed [15:0] adjusted_yaw_rate;
  } out_word_t;

endpackage

@@ rtl/qapm_if.sv @@
// ----------------------------------------------------------------------------
// qapm_if
// Valid/ready channel interfaces for sensor words, motor words and config.
// ----------------------------------------------------------------------------
interface qapm_in_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] roll_angle;
  logic signed [16:0] pitch_angle;
  logic signed [15:0] gyro_x;
  logic signed [15:0] gyro_y;
  logic signed [15:0] gyro_z;
  logic [11:0]        stick_roll;
  logic [11:0]        stick_pitch;
  logic [11:0]        stick_yaw;
  logic [11:0]        throttle;
  logic               armed;

  modport source (
    output valid, roll_angle, pitch_angle, gyro_x, gyro_y, gyro_z,
           stick_roll, stick_pitch, stick_yaw, throttle, armed,
    input  ready
  );
  modport sink (
    input  valid, roll_angle, pitch_angle, gyro_x, gyro_y, gyro_z,
           stick_roll, stick_pitch, stick_yaw, throttle, armed,
    output ready
  );
endinterface

interface qapm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] motor_front_a;
  logic signed [15:0] motor_front_b;
  logic signed [15:0] motor_rear_a;
  logic signed [15:0] motor_rear_b;
  logic signed [15:0] adjusted_yaw_rate;

  modport source (
    output valid, motor_front_a, motor_front_b, motor_rear_a, motor_rear_b,
           adjusted_yaw_rate,
    input  ready
  );
  modport sink (
    input  valid, motor_front_a, motor_front_b, motor_rear_a, motor_rear_b,
           adjusted_yaw_rate,
    output ready
  );
endinterface

interface qapm_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/qapm_front.sv @@
// ----------------------------------------------------------------------------
// qapm_front
// Input register and error stage: angle errors, stick setpoints and yaw rate.
// ----------------------------------------------------------------------------
module qapm_front import qapm_pkg::*; (
  input  logic      clk,
  input  in_word_t  din,
  input  logic      load_a,
  input  logic      load_b,
  output err_word_t b_word
);

  in_word_t  a_word;
  err_word_t b_word_next;

  // Truncating division of a stick offset by twelve.
  function automatic logic signed [8:0] div12(input logic signed [12:0] d);
    logic [12:0] neg;
    logic [11:0] mag;
    logic [24:0] prod;
    logic [7:0]  qm;
    neg  = 13'(-d);
    mag  = d[12] ? neg[11:0] : d[11:0];
    prod = 25'(mag) * 25'(DIV12_RECIP);
    qm   = prod[DIV12_SHIFT +: 8];
    return d[12] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
  endfunction

  always_ff @(posedge clk) begin
    if (load_a) begin
      a_word <= din;
    end
    if (load_b) begin
      b_word <= b_word_next;
    end
  end

  always_comb begin
    logic signed [12:0] d_roll;
    logic signed [12:0] d_pitch;
    logic signed [12:0] d_yaw;
    logic signed [8:0]  q_roll;
    logic signed [8:0]  q_pitch;
    logic signed [16:0] gz_sum;
    d_roll  = $signed({1'b0, a_word.stick_roll} - STICK_CENTRE);
    d_pitch = $signed({1'b0, a_word.stick_pitch} - STICK_CENTRE);
    d_yaw   = $signed({1'b0, a_word.stick_yaw} - STICK_CENTRE);
    q_roll  = div12(d_roll);
    q_pitch = div12(d_pitch);

    b_word_next.er = $signed({a_word.roll_angle[16], a_word.roll_angle})
                   - $signed({q_roll, 8'b0});
    b_word_next.ep = $signed({a_word.pitch_angle[16], a_word.pitch_angle})
                   + $signed({q_pitch, 8'b0});

    gz_sum = $signed({a_word.gyro_z[15], a_word.gyro_z})
           + $signed({{3{d_yaw[12]}}, d_yaw, 1'b0});
    if (a_word.stick_yaw < YAW_DEAD_LO || a_word.stick_yaw > YAW_DEAD_HI) begin
      if (gz_sum[16] != gz_sum[15]) begin
        b_word_next.gz = gz_sum[16] ? 16'sh8000 : 16'sh7fff;
      end else begin
        b_word_next.gz = gz_sum[15:0];
      end
    end else begin
      b_word_next.gz = a_word.gyro_z;
    end

    b_word_next.gx   = a_word.gyro_x;
    b_word_next.gy   = a_word.gyro_y;
    b_word_next.run  = (a_word.throttle > THROTTLE_MIN) && a_word.armed;
    b_word_next.low  = a_word.throttle < THROTTLE_MIN;
    b_word_next.base = a_word.throttle - THROTTLE_BASE;
  end

endmodule

@@ rtl/qapm_integ.sv @@
// ----------------------------------------------------------------------------
// qapm_integ
// Clamped roll and pitch integrators and the yaw angle accumulator.
// ----------------------------------------------------------------------------
module qapm_integ import qapm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  err_word_t   b_word,
  input  logic        load_c,
  output integ_word_t c_word
);

  logic signed [20:0] roll_integral;
  logic signed [20:0] pitch_integral;
  logic signed [21:0] yaw_accumulator;
  logic signed [20:0] roll_integral_next;
  logic signed [20:0] pitch_integral_next;
  logic signed [21:0] yaw_accumulator_next;
  integ_word_t        c_word_next;

  always_comb begin
    logic signed [21:0] ri_sum;
    logic signed [21:0] pi_sum;
    logic signed [22:0] ya_sum;
    logic signed [21:0] ri_clamp;
    logic signed [21:0] pi_clamp;
    logic signed [22:0] ya_clamp;
    ri_sum = $signed({roll_integral[20], roll_integral})
           + $signed({{4{b_word.er[17]}}, b_word.er});
    pi_sum = $signed({pitch_integral[20], pitch_integral})
           + $signed({{4{b_word.ep[17]}}, b_word.ep});
    ya_sum = $signed({yaw_accumulator[21], yaw_accumulator})
           + $signed({{4{b_word.gz[15]}}, b_word.gz, 3'b0});

    if (ri_sum > INTEG_LIMIT) begin
      ri_clamp = INTEG_LIMIT;
    end else if (ri_sum < -INTEG_LIMIT) begin
      ri_clamp = -INTEG_LIMIT;
    end else begin
      ri_clamp = ri_sum;
    end
    if (pi_sum > INTEG_LIMIT) begin
      pi_clamp = INTEG_LIMIT;
    end else if (pi_sum < -INTEG_LIMIT) begin
      pi_clamp = -INTEG_LIMIT;
    end else begin
      pi_clamp = pi_sum;
    end
    if (ya_sum > YAW_LIMIT) begin
      ya_clamp = YAW_LIMIT;
    end else if (ya_sum < -YAW_LIMIT) begin
      ya_clamp = -YAW_LIMIT;
    end else begin
      ya_clamp = ya_sum;
    end

    c_word_next.er   = b_word.er;
    c_word_next.ep   = b_word.ep;
    c_word_next.ri   = ri_clamp[20:0];
    c_word_next.pi   = pi_clamp[20:0];
    c_word_next.ya   = ya_clamp[21:0];
    c_word_next.gx   = b_word.gx;
    c_word_next.gy   = b_word.gy;
    c_word_next.gz   = b_word.gz;
    c_word_next.run  = b_word.run;
    c_word_next.base = b_word.base;

    // Low throttle clears the state after this tick's terms are formed.
    roll_integral_next   = b_word.low ? '0 : ri_clamp[20:0];
    pitch_integral_next  = b_word.low ? '0 : pi_clamp[20:0];
    yaw_accumulator_next = b_word.low ? '0 : ya_clamp[21:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      roll_integral   <= '0;
      pitch_integral  <= '0;
      yaw_accumulator <= '0;
    end else if (load_c) begin
      roll_integral   <= roll_integral_next;
      pitch_integral  <= pitch_integral_next;
      yaw_accumulator <= yaw_accumulator_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_c) begin
      c_word <= c_word_next;
    end
  end

endmodule

@@ rtl/qapm_terms.sv @@
// ----------------------------------------------------------------------------
// qapm_terms
// Gain products, then the summed roll, pitch and yaw terms at full precision.
// ----------------------------------------------------------------------------
module qapm_terms import qapm_pkg::*; (
  input  logic        clk,
  input  gains_t      gains,
  input  integ_word_t c_word,
  input  logic        load_d,
  input  logic        load_e,
  output rpy_word_t   e_word
);

  prod_word_t d_word;
  prod_word_t d_word_next;
  rpy_word_t  e_word_next;

  always_comb begin
    d_word_next.pr   = $signed({1'b0, gains.roll_p}) * c_word.er;
    d_word_next.ir   = $signed({1'b0, gains.roll_i}) * c_word.ri;
    d_word_next.dr   = $signed({1'b0, gains.roll_d}) * c_word.gy;
    d_word_next.pp   = $signed({1'b0, gains.pitch_p}) * c_word.ep;
    d_word_next.ip   = $signed({1'b0, gains.pitch_i}) * c_word.pi;
    d_word_next.dp   = $signed({1'b0, gains.pitch_d}) * c_word.gx;
    d_word_next.yp   = $signed({1'b0, gains.yaw_p}) * c_word.ya;
    d_word_next.yd   = $signed({1'b0, gains.yaw_d}) * c_word.gz;
    d_word_next.gz   = c_word.gz;
    d_word_next.run  = c_word.run;
    d_word_next.base = c_word.base;
  end

  always_comb begin
    e_word_next.r = -(SUM_W'(d_word.pr) <<< ERR_SHIFT)
                  - (SUM_W'(d_word.ir) <<< ERR_SHIFT)
                  - (SUM_W'(d_word.dr) <<< GYRO_SHIFT);
    e_word_next.p = (SUM_W'(d_word.pp) <<< ERR_SHIFT)
                  + (SUM_W'(d_word.ip) <<< ERR_SHIFT)
                  + (SUM_W'(d_word.dp) <<< GYRO_SHIFT);
    e_word_next.y = SUM_W'(d_word.yp)
                  + (SUM_W'(d_word.yd) <<< GYRO_SHIFT);
    e_word_next.base = $signed(SUM_W'(d_word.base) << SUM_SHIFT);
    e_word_next.gz   = d_word.gz;
    e_word_next.run  = d_word.run;
  end

  always_ff @(posedge clk) begin
    if (load_d) begin
      d_word <= d_word_next;
    end
    if (load_e) begin
      e_word <= e_word_next;
    end
  end

endmodule

@@ rtl/qapm_mix.sv @@
// ----------------------------------------------------------------------------
// qapm_mix
// X-frame motor mixing with truncation toward zero and int16 saturation.
// ----------------------------------------------------------------------------
module qapm_mix import qapm_pkg::*; (
  input  logic      clk,
  input  rpy_word_t e_word,
  input  logic      load_f,
  output out_word_t f_word
);

  localparam logic signed [SUM_W-1:0] MOTOR_MAX = 32767;
  localparam logic signed [SUM_W-1:0] MOTOR_MIN = -32768;
  localparam logic [SUM_W-1:0] FRAC_MASK = {SUM_W{1'b1}} >> (SUM_W - SUM_SHIFT);

  out_word_t f_word_next;

  function automatic logic signed [15:0] scale_sat(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] q;
    q = s >>> SUM_SHIFT;
    if (s[SUM_W-1] && ((s & FRAC_MASK) != '0)) begin
      q = q + SUM_W'(1);
    end
    if (q > MOTOR_MAX) begin
      return 16'sh7fff;
    end else if (q < MOTOR_MIN) begin
      return 16'sh8000;
    end else begin
      return q[15:0];
    end
  endfunction

  always_comb begin
    if (e_word.run) begin
      f_word_next.motor_front_a = scale_sat(e_word.base - e_word.r - e_word.p + e_word.y);
      f_word_next.motor_front_b = scale_sat(e_word.base + e_word.r - e_word.p - e_word.y);
      f_word_next.motor_rear_a  = scale_sat(e_word.base + e_word.r + e_word.p + e_word.y);
      f_word_next.motor_rear_b  = scale_sat(e_word.base - e_word.r + e_word.p - e_word.y);
    end else begin
      f_word_next.motor_front_a = '0;
      f_word_next.motor_front_b = '0;
      f_word_next.motor_rear_a  = '0;
      f_word_next.motor_rear_b  = '0;
    end
    f_word_next.adjusted_yaw_rate = e_word.gz;
  end

  always_ff @(posedge clk) begin
    if (load_f) begin
      f_word <= f_word_next;
    end
  end

endmodule

@@ rtl/quad_attitude_pid_mixer.sv @@
// ----------------------------------------------------------------------------
// quad_attitude_pid_mixer
// Attitude PID controller and X-frame motor mixer, one sensor word per tick.
// ----------------------------------------------------------------------------
// The block takes one sensor word every clock cycle while the output is not
// stalled and returns its motor word through a six-register pipeline: input,
// error, integrate, product, term sum and output. Each stage holds its word
// until the next is free, so a stalled output does not stop input while any
// stage is empty. The integrators and yaw accumulator update in the integrate
// stage as each word is loaded, setting the sustained rate at one word per
// cycle. Gain registers are written through the config channel, which is
// ready in every cycle outside reset.
module quad_attitude_pid_mixer import qapm_pkg::*; (
  input logic              clk,
  input logic              rst,
  qapm_in_if.sink          sensor,
  qapm_out_if.source       cmd,
  qapm_cfg_if.sink         cfg
);

  gains_t      gains;
  in_word_t    din;
  err_word_t   b_word;
  integ_word_t c_word;
  rpy_word_t   e_word;
  out_word_t   f_word;
  logic [5:0]  vld;
  logic [5:0]  free;
  logic [5:0]  load;

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      gains <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg_reg_t'(cfg.index))
        CFG_ROLL_P:  gains.roll_p  <= cfg.data;
        CFG_ROLL_I:  gains.roll_i  <= cfg.data;
        CFG_ROLL_D:  gains.roll_d  <= cfg.data;
        CFG_PITCH_P: gains.pitch_p <= cfg.data;
        CFG_PITCH_I: gains.pitch_i <= cfg.data;
        CFG_PITCH_D: gains.pitch_d <= cfg.data;
        CFG_YAW_P:   gains.yaw_p   <= cfg.data;
        CFG_YAW_D:   gains.yaw_d   <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    free[5] = !vld[5] || cmd.ready;
    for (int k = 4; k >= 0; k--) begin
      free[k] = !vld[k] || free[k+1];
    end
    load[0] = sensor.valid && free[0];
    for (int k = 1; k < 6; k++) begin
      load[k] = vld[k-1] && free[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= load | (vld & ~free);
    end
  end

  assign sensor.ready = free[0] && !rst;

  always_comb begin
    din.roll_angle  = sensor.roll_angle;
    din.pitch_angle = sensor.pitch_angle;
    din.gyro_x      = sensor.gyro_x;
    din.gyro_y      = sensor.gyro_y;
    din.gyro_z      = sensor.gyro_z;
    din.stick_roll  = sensor.stick_roll;
    din.stick_pitch = sensor.stick_pitch;
    din.stick_yaw   = sensor.stick_yaw;
    din.throttle    = sensor.throttle;
    din.armed       = sensor.armed;
  end

  qapm_front u_front (
    .clk    (clk),
    .din    (din),
    .load_a (load[0]),
    .load_b (load[1]),
    .b_word (b_word)
  );

  qapm_integ u_integ (
    .clk    (clk),
    .rst    (rst),
    .b_word (b_word),
    .load_c (load[2]),
    .c_word (c_word)
  );

  qapm_terms u_terms (
    .clk    (clk),
    .gains  (gains),
    .c_word (c_word),
    .load_d (load[3]),
    .load_e (load[4]),
    .e_word (e_word)
  );

  qapm_mix u_mix (
    .clk    (clk),
    .e_word (e_word),
    .load_f (load[5]),
    .f_word (f_word)
  );

  assign cmd.valid             = vld[5];
  assign cmd.motor_front_a     = f_word.motor_front_a;
  assign cmd.motor_front_b     = f_word.motor_front_b;
  assign cmd.motor_rear_a      = f_word.motor_rear_a;
  assign cmd.motor_rear_b      = f_word.motor_rear_b;
  assign cmd.adjusted_yaw_rate = f_word.adjusted_yaw_rate;

  // A stalled output must not block input while the first stage is empty.
  assert property (@(posedge clk) disable iff (rst)
    cmd.valid && !cmd.ready && !vld[0] |-> sensor.ready)
    else $error("input blocked with an empty input stage");

  // Words that are disarmed or at or below idle throttle leave with zero motors.
  assert property (@(posedge clk) disable iff (rst)
    load[5] && !e_word.run |=> cmd.motor_front_a == 16'sd0 &&
      cmd.motor_front_b == 16'sd0 && cmd.motor_rear_a == 16'sd0 &&
      cmd.motor_rear_b == 16'sd0)
    else $error("motor command not zero while stopped");

  // Integrated errors stay inside the clamp window.
  assert property (@(posedge clk) disable iff (rst)
    vld[2] |-> c_word.ri <= INTEG_LIMIT && c_word.ri >= -INTEG_LIMIT &&
      c_word.pi <= INTEG_LIMIT && c_word.pi >= -INTEG_LIMIT)
    else $error("integrator outside its limit");

endmodule
